### rtl/fhcs_pkg.sv
package fhcs_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_DIM        = 3;

  localparam int HEAT_W     = 17;
  localparam int MISS_W     = 16;
  localparam int DIGIT_W    = 4;
  localparam int POS_W      = 10;
  localparam int DIM_W      = 11;
  localparam int GAIN_W     = 16;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd700;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd500;
  localparam logic [GAIN_W-1:0] RST_COOLING_GAIN = 16'd8254;
  localparam logic [THR_W-1:0]  RST_STALE_THR    = 16'd2000;

  // 999.0 in Q10.6
  localparam int HEAT_MAX = 63936;

  localparam int ROUND_HALF  = 32768;
  localparam int GAIN_SHIFT  = 16;
  localparam int SCALE_BASE  = 90;
  localparam int SCALE_ROUND = 50;
  localparam int SCALE_W     = 7;
  localparam int DIGIT_MAX   = 9;

  // ceil(2^32 / 100): exact floor division by 100 for dividends below 2^30
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP100 = 26'd42949673;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_COOLING_GAIN,
    REG_STALE_THRESHOLD
  } cfg_reg_t;

endpackage

### rtl/fhcs_cfg_if.sv
interface fhcs_cfg_if;
  import fhcs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/fhcs_pix_in_if.sv
interface fhcs_pix_in_if;
  import fhcs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [HEAT_W-1:0] heat_in;
  logic [MISS_W-1:0]        miss_count;
  logic [DIGIT_W-1:0]       rand_digit;
  logic                     frame_start;

  modport source (output valid, output heat_in, output miss_count, output rand_digit,
                  output frame_start, input ready);
  modport sink   (input valid, input heat_in, input miss_count, input rand_digit,
                  input frame_start, output ready);
endinterface

### rtl/fhcs_pix_out_if.sv
interface fhcs_pix_out_if;
  import fhcs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         pos_x;
  logic [POS_W-1:0]         pos_y;
  logic signed [HEAT_W-1:0] heat_out;
  logic                     was_cooled;

  modport source (output valid, output pos_x, output pos_y, output heat_out,
                  output was_cooled, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heat_out,
                  input was_cooled, output ready);
endinterface

### rtl/fhcs_ram.sv
module fhcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fire_heat_cooling_stencil.sv
// Fire cooling filter, one pixel per beat, pixels processed one at a time.
// A pixel without result passes through read and write-back, plus a second
// write-back at the last column of a row. A pixel with result also passes multiply,
// scale, an optional divide and output, and the output state stalls under backpressure.
// The rate is set by the line-memory read/modify/write and the cooling multiply chain.
// Reset (rst, synchronous) restores register defaults, clears the window and
// the position counters; line memories are not cleared.
module fire_heat_cooling_stencil #(
  parameter int MAX_WIDTH  = fhcs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fhcs_pkg::DEF_MAX_HEIGHT
) (
  input  logic           clk,
  input  logic           rst,
  fhcs_cfg_if.sink       cfg,
  fhcs_pix_in_if.sink    pix_in,
  fhcs_pix_out_if.source pix_out
);
  import fhcs_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_HEIGHT + 1);
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int SUM_W  = HEAT_W + 3;
  localparam int PROD_W = SUM_W + GAIN_W + 1;
  localparam int AVG_W  = PROD_W - GAIN_SHIFT;
  localparam int P_W    = AVG_W - 1 + SCALE_W;
  localparam int QP_W   = P_W + RECIP_W;
  localparam int Q_W    = QP_W - RECIP_SHIFT;

  localparam logic signed [AVG_W-1:0]  AVG_MAX  = AVG_W'(HEAT_MAX);
  localparam logic signed [HEAT_W-1:0] HEAT_TOP = HEAT_W'(HEAT_MAX);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_SCL, ST_DIV, ST_OUT, ST_WB, ST_WB2
  } state_t;

  state_t state;

  // configuration
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [GAIN_W-1:0] cooling_gain;
  logic [THR_W-1:0]  stale_threshold;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= RST_FRAME_WIDTH;
      frame_height    <= RST_FRAME_HEIGHT;
      cooling_gain    <= RST_COOLING_GAIN;
      stale_threshold <= RST_STALE_THR;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:     frame_width     <= cfg.data[DIM_W-1:0];
        REG_FRAME_HEIGHT:    frame_height    <= cfg.data[DIM_W-1:0];
        REG_COOLING_GAIN:    cooling_gain    <= cfg.data[GAIN_W-1:0];
        REG_STALE_THRESHOLD: stale_threshold <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // position bookkeeping
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [31:0]   w32, h32;
  logic [CW-1:0] w_cl, cc0, c_acc;
  logic [RW-1:0] h_cl, rc0, r_acc;
  logic          wrap;
  logic          compute_acc, last_acc, stale_acc;
  logic [DIGIT_W-1:0] digit_acc;

  always_comb begin
    w32 = (32'(frame_width) < 32'(MIN_DIM)) ? 32'(MIN_DIM) :
          (32'(frame_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(frame_width);
    h32 = (32'(frame_height) < 32'(MIN_DIM)) ? 32'(MIN_DIM) :
          (32'(frame_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(frame_height);
    w_cl = w32[CW-1:0];
    h_cl = h32[RW-1:0];
    cc0  = pix_in.frame_start ? '0 : column_count;
    rc0  = pix_in.frame_start ? '0 : row_count;
    wrap = (cc0 >= w_cl);
    c_acc = wrap ? '0 : cc0;
    r_acc = (wrap && rc0 < h_cl) ? rc0 + RW'(1) : rc0;
    compute_acc = (r_acc >= RW'(2)) && (r_acc < h_cl) && (c_acc >= CW'(2));
    last_acc    = (c_acc == w_cl - CW'(1));
    stale_acc   = (pix_in.miss_count > stale_threshold);
    digit_acc   = (pix_in.rand_digit > DIGIT_W'(DIGIT_MAX)) ? DIGIT_W'(DIGIT_MAX)
                                                             : pix_in.rand_digit;
  end

  // item registers
  logic signed [HEAT_W-1:0] cur_q;
  logic [DIGIT_W-1:0]       digit_q;
  logic                     stale_this_q;
  logic [AW-1:0]            c_q;
  logic [RW-1:0]            r_q;
  logic                     compute_q, last_q;
  logic signed [HEAT_W-1:0] up_r_q, mid_r_q;
  logic                     stale_rd_q;

  // 3x2 window: upper row, middle row, current row; left and middle taps
  logic signed [HEAT_W-1:0] up_l, up_m, mid_l, mid_m, cur_l, cur_m;
  logic                     stale_prev;

  // line memories: each heat entry holds {upper line, middle line} of one column
  logic                    heat_we;
  logic [AW-1:0]           heat_waddr;
  logic [2*HEAT_W-1:0]     heat_wdata, heat_rdata;
  logic                    stale_we;
  logic [0:0]              stale_wdata, stale_rdata;
  logic signed [HEAT_W-1:0] up_rd, mid_rd;

  assign up_rd  = heat_rdata[2*HEAT_W-1:HEAT_W];
  assign mid_rd = heat_rdata[HEAT_W-1:0];

  fhcs_ram #(.WIDTH(2*HEAT_W), .DEPTH(MAX_WIDTH)) u_heat_ram (
    .clk   (clk),
    .we    (heat_we),
    .waddr (heat_waddr),
    .wdata (heat_wdata),
    .raddr (c_acc[AW-1:0]),
    .rdata (heat_rdata)
  );

  fhcs_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_stale_ram (
    .clk   (clk),
    .we    (stale_we),
    .waddr (c_q),
    .wdata (stale_wdata),
    .raddr (c_acc[AW-1:0]),
    .rdata (stale_rdata)
  );

  always_comb begin
    heat_we     = 1'b0;
    heat_waddr  = c_q;
    heat_wdata  = {mid_r_q, cur_q};
    stale_we    = 1'b0;
    stale_wdata = stale_this_q;
    case (state)
      ST_WB: begin
        // finished column to the left goes back to the lines, stale flag of this column too
        heat_we    = (c_q != '0);
        heat_waddr = c_q - AW'(1);
        heat_wdata = {mid_m, cur_m};
        stale_we   = 1'b1;
      end
      ST_WB2: begin
        heat_we = 1'b1;
      end
      default: ;
    endcase
  end

  // cooling datapath
  logic signed [SUM_W-1:0]  sum_c, sum_q;
  logic signed [PROD_W-1:0] prod_c, rnd_c;
  logic signed [AVG_W-1:0]  avg_c, avg_q;
  logic [SCALE_W-1:0]       scale_c;
  logic [P_W-1:0]           p_c, p_q;
  logic [QP_W-1:0]          qp_c;
  logic [Q_W-1:0]           q_c;
  logic signed [HEAT_W-1:0] avg_clamp, q_clamp, res_q;
  logic                     cooled_q;
  logic                     keep_c, avg_pos;

  always_comb begin
    sum_c = SUM_W'(up_l) + SUM_W'(up_m) + SUM_W'(up_rd) + SUM_W'(mid_l)
          + SUM_W'(mid_rd) + SUM_W'(cur_l) + SUM_W'(cur_m) + SUM_W'(cur_q);
    prod_c = sum_q * $signed({1'b0, cooling_gain});
    rnd_c  = prod_c + PROD_W'(ROUND_HALF);
    avg_c  = rnd_c[PROD_W-1:GAIN_SHIFT];
    keep_c  = (avg_q > mid_m);
    avg_pos = !avg_q[AVG_W-1] && (avg_q != '0);
    scale_c = SCALE_W'(SCALE_BASE) + SCALE_W'(digit_q);
    p_c     = avg_q[AVG_W-2:0] * scale_c + P_W'(SCALE_ROUND);
    avg_clamp = avg_q[AVG_W-1] ? '0 : (avg_q > AVG_MAX) ? HEAT_TOP : avg_q[HEAT_W-1:0];
    qp_c    = p_q * RECIP100;
    q_c     = qp_c[QP_W-1:RECIP_SHIFT];
    q_clamp = (q_c > Q_W'(HEAT_MAX)) ? HEAT_TOP : q_c[HEAT_W-1:0];
  end

  // result register
  logic                     out_valid;
  logic [POS_W-1:0]         out_pos_x, out_pos_y;
  logic signed [HEAT_W-1:0] out_heat;
  logic                     out_cooled;
  logic [31:0]              px_c, py_c;

  assign px_c = 32'(c_q) - 32'd1;
  assign py_c = 32'(r_q) - 32'd1;

  assign pix_in.ready       = (state == ST_IDLE);
  assign pix_out.valid      = out_valid;
  assign pix_out.pos_x      = out_pos_x;
  assign pix_out.pos_y      = out_pos_y;
  assign pix_out.heat_out   = out_heat;
  assign pix_out.was_cooled = out_cooled;

  logic do_shift;
  assign do_shift = (state == ST_WB2) || (state == ST_WB && !last_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= '0;
      row_count    <= '0;
      stale_prev   <= 1'b0;
      out_valid    <= 1'b0;
      up_l  <= '0;
      up_m  <= '0;
      mid_l <= '0;
      mid_m <= '0;
      cur_l <= '0;
      cur_m <= '0;
    end else begin
      // ST_OUT either reloads the result register or holds it under backpressure
      if (pix_out.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pix_in.valid) begin
            cur_q        <= pix_in.heat_in;
            digit_q      <= digit_acc;
            stale_this_q <= stale_acc;
            c_q          <= c_acc[AW-1:0];
            r_q          <= r_acc;
            compute_q    <= compute_acc;
            last_q       <= last_acc;
            row_count    <= r_acc;
            state        <= ST_RD;
          end
        end
        ST_RD: begin
          up_r_q     <= up_rd;
          mid_r_q    <= mid_rd;
          stale_rd_q <= stale_rdata[0];
          sum_q      <= sum_c;
          state      <= compute_q ? ST_MUL : ST_WB;
        end
        ST_MUL: begin
          avg_q <= avg_c;
          state <= ST_SCL;
        end
        ST_SCL: begin
          if (keep_c) begin
            res_q    <= mid_m;
            cooled_q <= 1'b0;
            state    <= ST_OUT;
          end else if (stale_prev && avg_pos) begin
            p_q      <= p_c;
            cooled_q <= 1'b1;
            state    <= ST_DIV;
          end else begin
            res_q    <= avg_clamp;
            cooled_q <= 1'b1;
            state    <= ST_OUT;
          end
        end
        ST_DIV: begin
          res_q <= q_clamp;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || pix_out.ready) begin
            out_valid  <= 1'b1;
            out_pos_x  <= px_c[POS_W-1:0];
            out_pos_y  <= py_c[POS_W-1:0];
            out_heat   <= res_q;
            out_cooled <= cooled_q;
            mid_m      <= res_q;
            state      <= ST_WB;
          end
        end
        ST_WB: begin
          // last column also stores its own entry, in ST_WB2
          if (last_q) begin
            state <= ST_WB2;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_WB2: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (do_shift) begin
        up_l         <= up_m;
        up_m         <= up_r_q;
        mid_l        <= mid_m;
        mid_m        <= mid_r_q;
        cur_l        <= cur_m;
        cur_m        <= cur_q;
        stale_prev   <= stale_rd_q;
        column_count <= CW'(c_q) + CW'(1);
      end
    end
  end

endmodule
